// ===== hw/rtl/dbc7_pkg.sv =====
package dbc7_pkg;

    localparam int NUM_BUTTONS    = 8;
    localparam int STABLE_SAMPLES = 12;
    localparam int HIST_W         = STABLE_SAMPLES + 1;
    localparam int LEVELS_W       = 8;
    localparam int COUNT_W        = 10;
    localparam int DIGITS_W       = 3;
    localparam int SEG_W          = 8;
    localparam int SUM_W          = COUNT_W + 1;

    localparam logic [HIST_W-1:0]   PRESS_PATTERN = HIST_W'(1) << STABLE_SAMPLES;
    localparam logic [COUNT_W-1:0]  COUNT_MAX     = COUNT_W'(1023);
    localparam logic [SEG_W-1:0]    BLANK_SEG     = 8'hFF;

    localparam logic [DIGITS_W-1:0] DIGITS_ONE   = 3'd1;
    localparam logic [DIGITS_W-1:0] DIGITS_TWO   = 3'd2;
    localparam logic [DIGITS_W-1:0] DIGITS_THREE = 3'd3;
    localparam logic [DIGITS_W-1:0] DIGITS_FOUR  = 3'd4;

    typedef struct packed {
        logic [COUNT_W-1:0]  count_value;
        logic [DIGITS_W-1:0] digits_shown;
        logic [SEG_W-1:0]    seg_ones;
        logic [SEG_W-1:0]    seg_tens;
        logic [SEG_W-1:0]    seg_hundreds;
        logic [SEG_W-1:0]    seg_thousands;
    } t_display;

    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = BLANK_SEG;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/dbc7_seg_decode.sv =====
module dbc7_seg_decode (
    input  logic [dbc7_pkg::COUNT_W-1:0] i_count,
    output dbc7_pkg::t_display           o_display
);
    import dbc7_pkg::*;

    logic [17:0]        w_p10;
    logic [15:0]        w_p100;
    logic [6:0]         w_q10;
    logic [3:0]         w_q100;
    logic [COUNT_W-1:0] w_ones_full;
    logic [6:0]         w_tens_full;
    logic [3:0]         w_ones;
    logic [3:0]         w_tens;
    logic [3:0]         w_hundreds;
    logic [3:0]         w_thousands;
    logic [DIGITS_W-1:0] w_digits;

    // divide by 10 and 100 through reciprocal multiply, exact below 1024
    assign w_p10  = {8'd0, i_count} * 18'd205;
    assign w_p100 = {6'd0, i_count} * 16'd41;
    assign w_q10  = w_p10[17:11];
    assign w_q100 = w_p100[15:12];

    assign w_ones_full = i_count - ({w_q10, 3'b000} + {2'b00, w_q10, 1'b0});
    assign w_tens_full = w_q10 - ({w_q100, 3'b000} + {2'b00, w_q100, 1'b0});
    assign w_ones      = w_ones_full[3:0];
    assign w_tens      = w_tens_full[3:0];
    assign w_hundreds  = (w_q100 >= 4'd10) ? (w_q100 - 4'd10) : w_q100;
    assign w_thousands = (i_count >= COUNT_W'(1000)) ? 4'd1 : 4'd0;

    always_comb begin
        if (i_count < COUNT_W'(10)) begin
            w_digits = DIGITS_ONE;
        end else if (i_count < COUNT_W'(100)) begin
            w_digits = DIGITS_TWO;
        end else if (i_count < COUNT_W'(1000)) begin
            w_digits = DIGITS_THREE;
        end else begin
            w_digits = DIGITS_FOUR;
        end
    end

    always_comb begin
        o_display.count_value   = i_count;
        o_display.digits_shown  = w_digits;
        o_display.seg_ones      = seg_code(w_ones);
        o_display.seg_tens      = (w_digits >= DIGITS_TWO) ? seg_code(w_tens) : BLANK_SEG;
        o_display.seg_hundreds  = (w_digits >= DIGITS_THREE) ? seg_code(w_hundreds)
                                                             : BLANK_SEG;
        o_display.seg_thousands = (w_digits >= DIGITS_FOUR) ? seg_code(w_thousands)
                                                            : BLANK_SEG;
    end

endmodule

// ===== hw/rtl/debounced_button_counter_7seg.sv =====
// Debounced button counter with a four-digit seven-segment readout. Each input
// transfer is one polling tick of eight raw active-low button pins; each button
// keeps a 13-sample history and a press counts once, when 12 pressed samples
// follow a released one. Button i adds 2^i to the count, and a sum above 1023
// becomes 1. Every tick yields one result transfer: the count, the number of
// lit digits and four active-low segment patterns (0xFF for unlit digits).
// The block takes one tick per clock cycle while the result side keeps accepting:
// the histories and the count update at the input transfer, and the decimal
// split and segment decode land in the output register once it can take them.
module debounced_button_counter_7seg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dbc7_pkg::LEVELS_W-1:0] i_button_levels,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dbc7_pkg::COUNT_W-1:0]  o_count_value,
    output logic [dbc7_pkg::DIGITS_W-1:0] o_digits_shown,
    output logic [dbc7_pkg::SEG_W-1:0]    o_seg_ones,
    output logic [dbc7_pkg::SEG_W-1:0]    o_seg_tens,
    output logic [dbc7_pkg::SEG_W-1:0]    o_seg_hundreds,
    output logic [dbc7_pkg::SEG_W-1:0]    o_seg_thousands
);
    import dbc7_pkg::*;

    logic [HIST_W-1:0]  r_hist [NUM_BUTTONS];
    logic [HIST_W-1:0]  n_hist [NUM_BUTTONS];
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_s1_valid;
    logic               r_out_valid;
    t_display           r_out;
    t_display           w_display;
    logic [SUM_W-1:0]   w_sum;
    logic               w_in_xfer;
    logic               w_out_load;

    assign w_out_load = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready    = !r_s1_valid || w_out_load;
    assign w_in_xfer  = i_valid && o_ready;

    always_comb begin
        w_sum = {1'b0, r_count};
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            n_hist[i] = {r_hist[i][HIST_W-2:0], i_button_levels[i]};
            if (n_hist[i] == PRESS_PATTERN) begin
                w_sum = w_sum + (SUM_W'(1) << i);
            end
        end
        n_count = (w_sum > {1'b0, COUNT_MAX}) ? COUNT_W'(1) : w_sum[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_hist[i] <= '0;
            end
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    r_hist[i] <= n_hist[i];
                end
                r_count    <= n_count;
                r_s1_valid <= 1'b1;
            end else if (w_out_load) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    dbc7_seg_decode u_decode (
        .i_count   (r_count),
        .o_display (w_display)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_display;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_count_value   = r_out.count_value;
    assign o_digits_shown  = r_out.digits_shown;
    assign o_seg_ones      = r_out.seg_ones;
    assign o_seg_tens      = r_out.seg_tens;
    assign o_seg_hundreds  = r_out.seg_hundreds;
    assign o_seg_thousands = r_out.seg_thousands;

    a_count_holds_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_out_load) |=> $stable(r_count))
        else $error("count changed while stage one stalled");

    a_digits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digits_shown == DIGITS_ONE || o_digits_shown == DIGITS_TWO ||
                     o_digits_shown == DIGITS_THREE || o_digits_shown == DIGITS_FOUR))
        else $error("digit count out of range");

    a_small_count_blanks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_count_value < COUNT_W'(10)) |->
            (o_digits_shown == DIGITS_ONE && o_seg_tens == BLANK_SEG &&
             o_seg_hundreds == BLANK_SEG && o_seg_thousands == BLANK_SEG))
        else $error("unlit digits not blanked");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (o_valid && o_count_value == $past(r_count)))
        else $error("output register missed a load");

endmodule

// ===== verif/dbc7_display_checker.sv =====
`timescale 1ns / 100ps

module dbc7_display_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [dbc7_pkg::LEVELS_W-1:0] i_button_levels,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [dbc7_pkg::COUNT_W-1:0]  i_count_value,
    input  logic [dbc7_pkg::DIGITS_W-1:0] i_digits_shown,
    input  logic [dbc7_pkg::SEG_W-1:0]    i_seg_ones,
    input  logic [dbc7_pkg::SEG_W-1:0]    i_seg_tens,
    input  logic [dbc7_pkg::SEG_W-1:0]    i_seg_hundreds,
    input  logic [dbc7_pkg::SEG_W-1:0]    i_seg_thousands,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_checked,
    output int                            o_presses,
    output int                            o_rollovers
);
    import dbc7_pkg::*;

    localparam logic [10*SEG_W-1:0] DECIMAL_SEGS = {
        8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
    };

    logic [HIST_W-1:0]  hist [NUM_BUTTONS];
    logic [COUNT_W-1:0] tally;
    t_display           expected_q [$];
    int                 err_count;
    int                 checked_count;
    int                 press_count;
    int                 rollover_count;
    int                 pending_count;

    assign o_errors    = err_count;
    assign o_checked   = checked_count;
    assign o_presses   = press_count;
    assign o_rollovers = rollover_count;
    assign o_pending   = pending_count;

    initial begin
        err_count      = 0;
        checked_count  = 0;
        press_count    = 0;
        rollover_count = 0;
        pending_count  = 0;
    end

    function automatic logic [SEG_W-1:0] decimal_seg(input int digit);
        return DECIMAL_SEGS[digit*SEG_W +: SEG_W];
    endfunction

    task automatic tick_display(input logic [LEVELS_W-1:0] levels, output t_display res);
        int sum;
        sum = int'(tally);
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            hist[b] = {hist[b][HIST_W-2:0], levels[b]};
            if (hist[b] == PRESS_PATTERN) begin
                sum += 1 << b;
                press_count++;
            end
        end
        if (sum > int'(COUNT_MAX)) begin
            sum = 1;
            rollover_count++;
        end
        tally = COUNT_W'(sum);
        res.count_value = tally;
        if (sum < 10) begin
            res.digits_shown = DIGITS_ONE;
        end else if (sum < 100) begin
            res.digits_shown = DIGITS_TWO;
        end else if (sum < 1000) begin
            res.digits_shown = DIGITS_THREE;
        end else begin
            res.digits_shown = DIGITS_FOUR;
        end
        res.seg_ones      = decimal_seg(sum % 10);
        res.seg_tens      = (sum >= 10) ? decimal_seg((sum / 10) % 10) : BLANK_SEG;
        res.seg_hundreds  = (sum >= 100) ? decimal_seg((sum / 100) % 10) : BLANK_SEG;
        res.seg_thousands = (sum >= 1000) ? decimal_seg((sum / 1000) % 10) : BLANK_SEG;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            err_count++;
            $display("%0t ns: %s mismatch, expected 'h%0h, actual 'h%0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_display want;
        if (!i_rst_n) begin
            foreach (hist[b]) hist[b] = '0;
            tally = '0;
            expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                checked_count++;
                if (expected_q.size() == 0) begin
                    err_count++;
                    $display("%0t ns: result transfer with nothing expected, actual count %0d",
                             $time, i_count_value);
                end else begin
                    want = expected_q.pop_front();
                    check_field("count_value", want.count_value, i_count_value);
                    check_field("digits_shown", want.digits_shown, i_digits_shown);
                    check_field("seg_ones", want.seg_ones, i_seg_ones);
                    check_field("seg_tens", want.seg_tens, i_seg_tens);
                    check_field("seg_hundreds", want.seg_hundreds, i_seg_hundreds);
                    check_field("seg_thousands", want.seg_thousands, i_seg_thousands);
                end
            end
            if (i_in_valid && i_in_ready) begin
                tick_display(i_button_levels, want);
                expected_q.push_back(want);
            end
        end
        pending_count <= expected_q.size();
    end

endmodule

// ===== verif/tb_debounced_button_counter_7seg.sv =====
`timescale 1ns / 100ps

module tb_debounced_button_counter_7seg;
    import dbc7_pkg::*;

    localparam int RANDOM_TICKS = 1100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 200;
    localparam int HOLD_AT      = 300;
    localparam int TAIL_CYCLES  = 8;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_valid         = 1'b0;
    logic                i_ready         = 1'b0;
    logic [LEVELS_W-1:0] i_button_levels = '1;
    logic                o_ready;
    logic                o_valid;
    logic [COUNT_W-1:0]  o_count_value;
    logic [DIGITS_W-1:0] o_digits_shown;
    logic [SEG_W-1:0]    o_seg_ones;
    logic [SEG_W-1:0]    o_seg_tens;
    logic [SEG_W-1:0]    o_seg_hundreds;
    logic [SEG_W-1:0]    o_seg_thousands;

    int chk_errors;
    int chk_pending;
    int chk_checked;
    int chk_presses;
    int chk_rollovers;

    int ticks_sent   = 0;
    int send_burst   = 0;
    int cycle_count  = 0;
    bit want_press [NUM_BUTTONS];
    int stretch_left [NUM_BUTTONS];
    int bounce_left [NUM_BUTTONS];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    debounced_button_counter_7seg u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_button_levels (i_button_levels),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_count_value   (o_count_value),
        .o_digits_shown  (o_digits_shown),
        .o_seg_ones      (o_seg_ones),
        .o_seg_tens      (o_seg_tens),
        .o_seg_hundreds  (o_seg_hundreds),
        .o_seg_thousands (o_seg_thousands)
    );

    dbc7_display_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_button_levels (i_button_levels),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_count_value   (o_count_value),
        .i_digits_shown  (o_digits_shown),
        .i_seg_ones      (o_seg_ones),
        .i_seg_tens      (o_seg_tens),
        .i_seg_hundreds  (o_seg_hundreds),
        .i_seg_thousands (o_seg_thousands),
        .o_errors        (chk_errors),
        .o_pending       (chk_pending),
        .o_checked       (chk_checked),
        .o_presses       (chk_presses),
        .o_rollovers     (chk_rollovers)
    );

    task automatic send_tick(input logic [LEVELS_W-1:0] levels);
        int gap;
        if (send_burst > 0) begin
            gap = 0;
            send_burst--;
        end else begin
            gap = $urandom_range(0, 16);
            if ($urandom_range(0, 49) == 0) send_burst = $urandom_range(20, 80);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_button_levels <= levels;
        do @(posedge i_clk); while (!o_ready);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic press_round(input logic [LEVELS_W-1:0] mask);
        send_tick('1);
        repeat (STABLE_SAMPLES) send_tick(~mask);
    endtask

    task automatic random_tick();
        logic [LEVELS_W-1:0] levels;
        if ($urandom_range(0, 9) == 0) begin
            levels = LEVELS_W'($urandom_range(0, 255));
        end else begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                if (stretch_left[b] == 0) begin
                    want_press[b] = !want_press[b];
                    if (!want_press[b]) begin
                        stretch_left[b] = $urandom_range(1, 8);
                    end else if ($urandom_range(0, 3) == 0) begin
                        stretch_left[b] = $urandom_range(1, STABLE_SAMPLES - 1);
                    end else begin
                        stretch_left[b] = $urandom_range(STABLE_SAMPLES, 2 * STABLE_SAMPLES);
                    end
                    bounce_left[b] = $urandom_range(0, 3);
                end
                if (bounce_left[b] > 0) begin
                    levels[b] = 1'($urandom_range(0, 1));
                    bounce_left[b]--;
                end else begin
                    levels[b] = !want_press[b];
                end
                stretch_left[b]--;
            end
        end
        send_tick(levels);
    endtask

    // output side: random stalls, idle-free stretches, one long hold-off
    initial begin
        int gap;
        int burst;
        int taken;
        burst = 0;
        taken = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (taken == HOLD_AT) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                if (burst > 0) begin
                    gap = 0;
                    burst--;
                end else begin
                    gap = $urandom_range(0, 16);
                    if ($urandom_range(0, 49) == 0) burst = $urandom_range(20, 80);
                end
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            taken++;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // held since reset, then all buttons together up to 1020, exactly 1023, then rollover
        repeat (STABLE_SAMPLES + 2) send_tick('0);
        repeat (4) press_round('1);
        press_round(8'h03);
        press_round(8'h01);
        send_tick(8'hAA);
        send_tick(8'h55);
        send_tick('1);

        repeat (RANDOM_TICKS) random_tick();
        i_valid <= 1'b0;

        while (chk_pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Run covered %0d polling ticks and %0d display results", ticks_sent, chk_checked);
        $display("with %0d debounced presses, %0d count rollovers and a %0d-cycle output stall",
                 chk_presses, chk_rollovers, LONG_HOLD);
        if (chk_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
